[design/gpcc_pkg.sv]
`timescale 1ns / 1ps
// Package for the GPIO pin configuration controller.
// Sizes, command codes and the command and status structs between controller and datapath; no dependencies.
package gpcc_pkg;

    localparam int PIN_COUNT     = 24;
    localparam int NUM_IRQ_LINES = 8;
    localparam int FUNC_BITS     = 32;
    localparam int IRQ_FIRST_PIN = 16;
    localparam int IRQ_LAST_PIN  = 23;

    localparam int CMD_W   = 5;
    localparam int PIN_W   = 5;
    localparam int SET_W   = 2;
    localparam int FBIT_W  = 5;
    localparam int LINE_W  = 3;
    localparam int RES_W   = 3;
    localparam int PAD_W   = 24;
    localparam int IRQEN_W = 8;

    localparam logic [CMD_W-1:0] CMD_SET_PULL   = 5'd0;
    localparam logic [CMD_W-1:0] CMD_SET_DRIVE  = 5'd1;
    localparam logic [CMD_W-1:0] CMD_SET_SLEW   = 5'd2;
    localparam logic [CMD_W-1:0] CMD_SET_TYPE   = 5'd3;
    localparam logic [CMD_W-1:0] CMD_GET_PULL   = 5'd4;
    localparam logic [CMD_W-1:0] CMD_GET_DRIVE  = 5'd5;
    localparam logic [CMD_W-1:0] CMD_GET_SLEW   = 5'd6;
    localparam logic [CMD_W-1:0] CMD_GET_TYPE   = 5'd7;
    localparam logic [CMD_W-1:0] CMD_WR_LEVEL   = 5'd8;
    localparam logic [CMD_W-1:0] CMD_RD_PAD     = 5'd9;
    localparam logic [CMD_W-1:0] CMD_MK_INPUT   = 5'd10;
    localparam logic [CMD_W-1:0] CMD_MK_OUTPUT  = 5'd11;
    localparam logic [CMD_W-1:0] CMD_FUNC_EN    = 5'd12;
    localparam logic [CMD_W-1:0] CMD_FUNC_DIS   = 5'd13;
    localparam logic [CMD_W-1:0] CMD_IRQ_UNMASK = 5'd14;
    localparam logic [CMD_W-1:0] CMD_IRQ_MASK   = 5'd15;
    localparam logic [CMD_W-1:0] CMD_IRQ_LINE   = 5'd16;

    // controller -> datapath
    typedef struct packed {
        logic load;     // latch the incoming transaction and update state
    } gpcc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic res_err;  // result register holds an error response
    } gpcc_status_t;

endpackage

[design/gpcc_ctrl.sv]
`timescale 1ns / 1ps
// Handshake controller for the GPIO pin configuration controller.
// Tracks whether the result register is occupied; uses gpcc_pkg.
module gpcc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    input  gpcc_pkg::gpcc_status_t status,
    output gpcc_pkg::gpcc_cmd_t   cmd
);
    import gpcc_pkg::*;

    localparam logic ST_EMPTY = 1'b0;
    localparam logic ST_FULL  = 1'b1;

    logic state_reg;
    logic state_next;

    // a new transaction may enter in the same cycle the old result leaves
    assign cmd_stall = (state_reg == ST_FULL) && rsp_stall;
    assign cmd.load  = cmd_valid && !cmd_stall;
    assign rsp_valid = (state_reg == ST_FULL);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_EMPTY:
            begin
                if (cmd.load)
                    state_next = ST_FULL;
            end
            ST_FULL:
            begin
                if (!cmd.load && !rsp_stall)
                    state_next = ST_EMPTY;
            end
            default: state_next = ST_EMPTY;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_EMPTY;
        else
            state_reg <= state_next;
    end

`ifndef SYNTHESIS
    a_load_fills: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> rsp_valid)
        else $error("result not presented after accepted transaction");
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(status.res_err)))
        else $error("stalled result was dropped or changed");
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_stall && !cmd_valid) |=> !rsp_valid)
        else $error("result register did not empty");
`endif

endmodule

[design/gpcc_datapath.sv]
`timescale 1ns / 1ps
// Datapath of the GPIO pin configuration controller: pin vectors, function word,
// irq mask and the result register. Uses gpcc_pkg.
module gpcc_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  gpcc_pkg::gpcc_cmd_t            cmd,
    output gpcc_pkg::gpcc_status_t         status,
    input  logic [gpcc_pkg::CMD_W-1:0]     command,
    input  logic [gpcc_pkg::PIN_W-1:0]     pin,
    input  logic [gpcc_pkg::SET_W-1:0]     setting,
    input  logic [gpcc_pkg::FBIT_W-1:0]    function_bit,
    input  logic [gpcc_pkg::LINE_W-1:0]    irq_line,
    input  logic [gpcc_pkg::PAD_W-1:0]     pad_levels,
    output logic [gpcc_pkg::RES_W-1:0]     result_value,
    output logic                           error,
    output logic [gpcc_pkg::PAD_W-1:0]     pad_out_value,
    output logic [gpcc_pkg::PAD_W-1:0]     pad_out_enable,
    output logic [gpcc_pkg::PAD_W-1:0]     pad_in_enable,
    output logic [gpcc_pkg::IRQEN_W-1:0]   irq_enables
);
    import gpcc_pkg::*;

    logic [PIN_COUNT-1:0]     pull_en_reg,  pull_en_next;
    logic [PIN_COUNT-1:0]     pull_sel_reg, pull_sel_next;
    logic [PIN_COUNT-1:0]     drv_lo_reg,   drv_lo_next;
    logic [PIN_COUNT-1:0]     drv_hi_reg,   drv_hi_next;
    logic [PIN_COUNT-1:0]     slew_reg,     slew_next;
    logic [PIN_COUNT-1:0]     in_mode_reg,  in_mode_next;
    logic [PIN_COUNT-1:0]     out_lvl_reg,  out_lvl_next;
    logic [PIN_COUNT-1:0]     out_en_reg,   out_en_next;
    logic [PIN_COUNT-1:0]     in_en_reg,    in_en_next;
    logic [FUNC_BITS-1:0]     func_en_reg,  func_en_next;
    logic [NUM_IRQ_LINES-1:0] irq_msk_reg,  irq_msk_next;
    logic [RES_W-1:0]         res_val_reg,  res_val_next;
    logic                     res_err_reg,  res_err_next;

    logic                     pin_ok;
    logic                     line_ok;
    logic                     irq_pin_ok;
    logic                     lvl;
    logic [PIN_COUNT-1:0]     pin_sel;
    logic [PIN_COUNT-1:0]     pin_setb0;
    logic [PIN_COUNT-1:0]     pin_setb1;
    logic [PIN_COUNT-1:0]     pin_lvl;
    logic [FUNC_BITS-1:0]     fbit_sel;
    logic [NUM_IRQ_LINES-1:0] line_sel;
    logic [PIN_W:0]           pin_rel;

    assign pin_ok     = 32'(pin) < PIN_COUNT;
    assign line_ok    = 32'(irq_line) < NUM_IRQ_LINES;
    assign pin_rel    = {1'b0, pin} - (PIN_W + 1)'(IRQ_FIRST_PIN);
    assign irq_pin_ok = pin_ok && (32'(pin) >= IRQ_FIRST_PIN) && (32'(pin) <= IRQ_LAST_PIN)
                        && (32'(pin_rel) < NUM_IRQ_LINES);
    assign lvl        = |setting;

    // one-hot pin decode, empty when the pin is out of range
    assign pin_sel   = pin_ok ? (PIN_COUNT'(1) << pin) : '0;
    assign pin_setb0 = setting[0] ? pin_sel : '0;
    assign pin_setb1 = setting[1] ? pin_sel : '0;
    assign pin_lvl   = lvl ? pin_sel : '0;
    assign fbit_sel  = FUNC_BITS'(1) << function_bit;
    assign line_sel  = line_ok ? (NUM_IRQ_LINES'(1) << irq_line) : '0;

    always_comb
    begin
        pull_en_next  = pull_en_reg;
        pull_sel_next = pull_sel_reg;
        drv_lo_next   = drv_lo_reg;
        drv_hi_next   = drv_hi_reg;
        slew_next     = slew_reg;
        in_mode_next  = in_mode_reg;
        out_lvl_next  = out_lvl_reg;
        out_en_next   = out_en_reg;
        in_en_next    = in_en_reg;
        func_en_next  = func_en_reg;
        irq_msk_next  = irq_msk_reg;
        res_val_next  = '0;
        res_err_next  = 1'b0;
        unique case (command)
            CMD_SET_PULL:
            begin
                pull_en_next  = (pull_en_reg & ~pin_sel) | pin_lvl;
                pull_sel_next = (pull_sel_reg & ~pin_sel)
                                | ((setting == SET_W'(2)) ? pin_sel : '0);
            end
            CMD_SET_DRIVE:
            begin
                drv_lo_next = (drv_lo_reg & ~pin_sel) | pin_setb0;
                drv_hi_next = (drv_hi_reg & ~pin_sel) | pin_setb1;
            end
            CMD_SET_SLEW: slew_next    = (slew_reg & ~pin_sel) | pin_setb0;
            CMD_SET_TYPE: in_mode_next = (in_mode_reg & ~pin_sel) | pin_setb0;
            CMD_GET_PULL:
            begin
                if (|(pull_en_reg & pin_sel))
                    res_val_next = (|(pull_sel_reg & pin_sel)) ? RES_W'(2) : RES_W'(1);
            end
            CMD_GET_DRIVE:
                res_val_next = {1'b0, |(drv_hi_reg & pin_sel), |(drv_lo_reg & pin_sel)};
            CMD_GET_SLEW: res_val_next = RES_W'(|(slew_reg & pin_sel));
            CMD_GET_TYPE: res_val_next = RES_W'(|(in_mode_reg & pin_sel));
            CMD_WR_LEVEL: out_lvl_next = (out_lvl_reg & ~pin_sel) | pin_lvl;
            CMD_RD_PAD:   res_val_next = RES_W'(|(pad_levels & pin_sel));
            CMD_MK_INPUT:
            begin
                out_en_next = out_en_reg & ~pin_sel;
                in_en_next  = in_en_reg | pin_sel;
            end
            CMD_MK_OUTPUT:
            begin
                out_lvl_next = (out_lvl_reg & ~pin_sel) | pin_lvl;
                in_en_next   = in_en_reg & ~pin_sel;
                out_en_next  = out_en_reg | pin_sel;
            end
            CMD_FUNC_EN:    func_en_next = func_en_reg | fbit_sel;
            CMD_FUNC_DIS:   func_en_next = func_en_reg & ~fbit_sel;
            CMD_IRQ_UNMASK: irq_msk_next = irq_msk_reg | line_sel;
            CMD_IRQ_MASK:   irq_msk_next = irq_msk_reg & ~line_sel;
            CMD_IRQ_LINE:
            begin
                if (irq_pin_ok)
                    res_val_next = pin_rel[RES_W-1:0];
                else
                    res_err_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pull_en_reg  <= '0;
            pull_sel_reg <= '0;
            drv_lo_reg   <= '0;
            drv_hi_reg   <= '0;
            slew_reg     <= '0;
            in_mode_reg  <= '0;
            out_lvl_reg  <= '0;
            out_en_reg   <= '0;
            in_en_reg    <= '0;
            func_en_reg  <= '0;
            irq_msk_reg  <= '0;
        end
        else if (cmd.load)
        begin
            pull_en_reg  <= pull_en_next;
            pull_sel_reg <= pull_sel_next;
            drv_lo_reg   <= drv_lo_next;
            drv_hi_reg   <= drv_hi_next;
            slew_reg     <= slew_next;
            in_mode_reg  <= in_mode_next;
            out_lvl_reg  <= out_lvl_next;
            out_en_reg   <= out_en_next;
            in_en_reg    <= in_en_next;
            func_en_reg  <= func_en_next;
            irq_msk_reg  <= irq_msk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            res_val_reg <= res_val_next;
            res_err_reg <= res_err_next;
        end
    end

    // state only moves on load, so the live vectors are the post-command snapshot
    assign result_value   = res_val_reg;
    assign error          = res_err_reg;
    assign pad_out_value  = PAD_W'(out_lvl_reg);
    assign pad_out_enable = PAD_W'(out_en_reg);
    assign pad_in_enable  = PAD_W'(in_en_reg);
    assign irq_enables    = IRQEN_W'(irq_msk_reg);
    assign status.res_err = res_err_reg;

`ifndef SYNTHESIS
    a_dir_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (out_en_reg & in_en_reg) == '0)
        else $error("pin enabled as input and output at once");
    a_err_zero_val: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load && (command == CMD_IRQ_LINE) && !irq_pin_ok |=> res_val_reg == '0)
        else $error("error response carries nonzero value");
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.load |=> ($stable(out_lvl_reg) && $stable(irq_msk_reg) && $stable(func_en_reg)))
        else $error("state changed without a transaction");
`endif

endmodule

[design/gpio_pin_config_controller.sv]
`timescale 1ns / 1ps
// Top level of the GPIO pin configuration controller.
// Instantiates gpcc_ctrl and gpcc_datapath; uses gpcc_pkg.
//
// Each command transaction reads or updates one pin, one function bit or one
// interrupt line and produces exactly one response in the cycle after it is taken.
// The response carries the read value, an error flag (set only for a pin-to-irq
// query on a pin without a line) and the pad output level, output enable, input
// enable and irq enable vectors as they stand after the command. A single
// result register separates the two channels: a new command is taken every
// cycle as long as the response side does not stall, so the sustained rate is
// one command per clock. All configuration state clears to zero on reset; the
// result register is not reset.
module gpio_pin_config_controller (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    output logic                           cmd_stall,
    input  logic [gpcc_pkg::CMD_W-1:0]     command,
    input  logic [gpcc_pkg::PIN_W-1:0]     pin,
    input  logic [gpcc_pkg::SET_W-1:0]     setting,
    input  logic [gpcc_pkg::FBIT_W-1:0]    function_bit,
    input  logic [gpcc_pkg::LINE_W-1:0]    irq_line,
    input  logic [gpcc_pkg::PAD_W-1:0]     pad_levels,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [gpcc_pkg::RES_W-1:0]     result_value,
    output logic                           error,
    output logic [gpcc_pkg::PAD_W-1:0]     pad_out_value,
    output logic [gpcc_pkg::PAD_W-1:0]     pad_out_enable,
    output logic [gpcc_pkg::PAD_W-1:0]     pad_in_enable,
    output logic [gpcc_pkg::IRQEN_W-1:0]   irq_enables
);
    import gpcc_pkg::*;

    gpcc_cmd_t    cmd;
    gpcc_status_t status;

    gpcc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .cmd       (cmd)
    );

    gpcc_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .command        (command),
        .pin            (pin),
        .setting        (setting),
        .function_bit   (function_bit),
        .irq_line       (irq_line),
        .pad_levels     (pad_levels),
        .result_value   (result_value),
        .error          (error),
        .pad_out_value  (pad_out_value),
        .pad_out_enable (pad_out_enable),
        .pad_in_enable  (pad_in_enable),
        .irq_enables    (irq_enables)
    );

endmodule

[tb/gpcc_checker.sv]
`timescale 1ns / 1ps
// Response checker for the GPIO pin configuration controller testbench.
// Watches the command and response channels, predicts each response and compares it.
// Depends on gpcc_pkg.
module gpcc_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    input  logic                           cmd_stall,
    input  logic [gpcc_pkg::CMD_W-1:0]     command,
    input  logic [gpcc_pkg::PIN_W-1:0]     pin,
    input  logic [gpcc_pkg::SET_W-1:0]     setting,
    input  logic [gpcc_pkg::FBIT_W-1:0]    function_bit,
    input  logic [gpcc_pkg::LINE_W-1:0]    irq_line,
    input  logic [gpcc_pkg::PAD_W-1:0]     pad_levels,
    input  logic                           rsp_valid,
    input  logic                           rsp_stall,
    input  logic [gpcc_pkg::RES_W-1:0]     result_value,
    input  logic                           error,
    input  logic [gpcc_pkg::PAD_W-1:0]     pad_out_value,
    input  logic [gpcc_pkg::PAD_W-1:0]     pad_out_enable,
    input  logic [gpcc_pkg::PAD_W-1:0]     pad_in_enable,
    input  logic [gpcc_pkg::IRQEN_W-1:0]   irq_enables,
    output int                             fail_count,
    output int                             pending
);
    import gpcc_pkg::*;

    typedef struct packed {
        logic [RES_W-1:0]   value;
        logic               err;
        logic [PAD_W-1:0]   out_val;
        logic [PAD_W-1:0]   out_en;
        logic [PAD_W-1:0]   in_en;
        logic [IRQEN_W-1:0] irq_en;
    } pin_rsp_t;

    pin_rsp_t expected_rsps[$];

    // shadow copy of the controller state
    logic [PIN_COUNT-1:0]     pull_en, pull_sel, drv_lo, drv_hi, slew, in_type;
    logic [PIN_COUNT-1:0]     lvl_q, oe_q, ie_q;
    logic [FUNC_BITS-1:0]     func_en;
    logic [NUM_IRQ_LINES-1:0] irq_mask;

    initial fail_count = 0;

    function automatic pin_rsp_t apply_command(
        input logic [CMD_W-1:0]  c,
        input logic [PIN_W-1:0]  p,
        input logic [SET_W-1:0]  s,
        input logic [FBIT_W-1:0] fb,
        input logic [LINE_W-1:0] ln,
        input logic [PAD_W-1:0]  pads
    );
        pin_rsp_t r;
        logic     pin_ok;
        logic     lvl;
        r = '0;
        pin_ok = (p < PIN_COUNT);
        lvl = (s != 0);
        case (c)
            CMD_SET_PULL:
                if (pin_ok)
                begin
                    pull_en[p] = lvl;
                    pull_sel[p] = (s == 2);   // setting 3 leaves select clear
                end
            CMD_SET_DRIVE:
                if (pin_ok)
                begin
                    drv_lo[p] = s[0];
                    drv_hi[p] = s[1];
                end
            CMD_SET_SLEW:   if (pin_ok) slew[p] = s[0];
            CMD_SET_TYPE:   if (pin_ok) in_type[p] = s[0];
            CMD_GET_PULL:
                if (pin_ok && pull_en[p])
                    r.value = pull_sel[p] ? 3'd2 : 3'd1;
            CMD_GET_DRIVE:  if (pin_ok) r.value = {1'b0, drv_hi[p], drv_lo[p]};
            CMD_GET_SLEW:   if (pin_ok) r.value = RES_W'(slew[p]);
            CMD_GET_TYPE:   if (pin_ok) r.value = RES_W'(in_type[p]);
            CMD_WR_LEVEL:   if (pin_ok) lvl_q[p] = lvl;
            CMD_RD_PAD:     if (pin_ok) r.value = RES_W'(pads[p]);
            CMD_MK_INPUT:
                if (pin_ok)
                begin
                    oe_q[p] = 1'b0;
                    ie_q[p] = 1'b1;
                end
            CMD_MK_OUTPUT:
                if (pin_ok)
                begin
                    lvl_q[p] = lvl;
                    ie_q[p] = 1'b0;
                    oe_q[p] = 1'b1;
                end
            CMD_FUNC_EN:    func_en[fb] = 1'b1;
            CMD_FUNC_DIS:   func_en[fb] = 1'b0;
            CMD_IRQ_UNMASK: if (ln < NUM_IRQ_LINES) irq_mask[ln] = 1'b1;
            CMD_IRQ_MASK:   if (ln < NUM_IRQ_LINES) irq_mask[ln] = 1'b0;
            CMD_IRQ_LINE:
                if (pin_ok && p >= IRQ_FIRST_PIN && p <= IRQ_LAST_PIN
                    && p - IRQ_FIRST_PIN < NUM_IRQ_LINES)
                    r.value = RES_W'(p - IRQ_FIRST_PIN);
                else
                    r.err = 1'b1;
            default: ;
        endcase
        r.out_val = lvl_q;
        r.out_en = oe_q;
        r.in_en = ie_q;
        r.irq_en = irq_mask;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : monitor
        pin_rsp_t want;
        if (!rst_n)
        begin
            pull_en = '0; pull_sel = '0; drv_lo = '0; drv_hi = '0;
            slew = '0; in_type = '0; lvl_q = '0; oe_q = '0; ie_q = '0;
            func_en = '0; irq_mask = '0;
            expected_rsps.delete();
        end
        else
        begin
            // response registered, so a response never belongs to this edge's command
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    fail_count++;
                    $display("%0t ns: response expected none actual value %0h err %0b",
                             $time, result_value, error);
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    check_field("result_value", 32'(want.value), 32'(result_value));
                    check_field("error", 32'(want.err), 32'(error));
                    check_field("pad_out_value", 32'(want.out_val), 32'(pad_out_value));
                    check_field("pad_out_enable", 32'(want.out_en), 32'(pad_out_enable));
                    check_field("pad_in_enable", 32'(want.in_en), 32'(pad_in_enable));
                    check_field("irq_enables", 32'(want.irq_en), 32'(irq_enables));
                end
            end
            if (cmd_valid && !cmd_stall)
                expected_rsps.push_back(apply_command(command, pin, setting,
                                                      function_bit, irq_line, pad_levels));
        end
        pending = expected_rsps.size();
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Testbench top for the GPIO pin configuration controller.
// Drives directed and random command transactions; gpcc_checker does the checking.
// Depends on gpcc_pkg, gpio_pin_config_controller and gpcc_checker.
module tb;
    import gpcc_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED_TOP = 5'd31;
    localparam int RANDOM_ITEMS = 1500;
    localparam int QUIET_ITEMS  = 150;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 8;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cmd_valid = 1'b0;
    logic                cmd_stall;
    logic [CMD_W-1:0]    command = '0;
    logic [PIN_W-1:0]    pin = '0;
    logic [SET_W-1:0]    setting = '0;
    logic [FBIT_W-1:0]   function_bit = '0;
    logic [LINE_W-1:0]   irq_line = '0;
    logic [PAD_W-1:0]    pad_levels = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    logic [RES_W-1:0]    result_value;
    logic                error;
    logic [PAD_W-1:0]    pad_out_value;
    logic [PAD_W-1:0]    pad_out_enable;
    logic [PAD_W-1:0]    pad_in_enable;
    logic [IRQEN_W-1:0]  irq_enables;
    int                  fail_count;
    int                  pending;
    logic                quiet = 1'b0;   // no idling on either side

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    gpio_pin_config_controller DUT (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
        .command(command), .pin(pin), .setting(setting),
        .function_bit(function_bit), .irq_line(irq_line), .pad_levels(pad_levels),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
        .result_value(result_value), .error(error),
        .pad_out_value(pad_out_value), .pad_out_enable(pad_out_enable),
        .pad_in_enable(pad_in_enable), .irq_enables(irq_enables)
    );

    gpcc_checker u_check (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
        .command(command), .pin(pin), .setting(setting),
        .function_bit(function_bit), .irq_line(irq_line), .pad_levels(pad_levels),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
        .result_value(result_value), .error(error),
        .pad_out_value(pad_out_value), .pad_out_enable(pad_out_enable),
        .pad_in_enable(pad_in_enable), .irq_enables(irq_enables),
        .fail_count(fail_count), .pending(pending)
    );

    // one command transaction, then maybe an idle burst
    task automatic send_command(
        input logic [CMD_W-1:0]  c,
        input logic [PIN_W-1:0]  p,
        input logic [SET_W-1:0]  s,
        input logic [FBIT_W-1:0] fb,
        input logic [LINE_W-1:0] ln,
        input logic [PAD_W-1:0]  pads
    );
        cmd_valid <= 1'b1;
        command <= c;
        pin <= p;
        setting <= s;
        function_bit <= fb;
        irq_line <= ln;
        pad_levels <= pads;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    task automatic random_command();
        logic [CMD_W-1:0] c;
        logic [PIN_W-1:0] p;
        if ($urandom_range(0, 9) == 0)
            c = CMD_W'($urandom_range(CMD_IRQ_LINE + 1, CMD_UNUSED_TOP));
        else
            c = CMD_W'($urandom_range(CMD_SET_PULL, CMD_IRQ_LINE));
        if (c == CMD_IRQ_LINE && $urandom_range(0, 1) == 0)
            p = PIN_W'($urandom_range(IRQ_FIRST_PIN - 2, IRQ_LAST_PIN + 2));
        else if ($urandom_range(0, 9) == 0)
            p = PIN_W'($urandom_range(PIN_COUNT, 31));
        else
            p = PIN_W'($urandom_range(0, PIN_COUNT - 1));
        send_command(c, p, SET_W'($urandom_range(0, 3)),
                     FBIT_W'($urandom_range(0, FUNC_BITS - 1)),
                     LINE_W'($urandom_range(0, NUM_IRQ_LINES - 1)), PAD_W'($urandom()));
    endtask

    initial
    begin : rsp_side
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (quiet || $urandom_range(0, 2) != 0)
            begin
                rsp_stall <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
            else
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        int k;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pull encodings, including setting 3 giving select clear
        send_command(CMD_SET_PULL, 0, 2, 0, 0, 0);
        send_command(CMD_GET_PULL, 0, 0, 0, 0, 0);
        send_command(CMD_SET_PULL, 0, 3, 0, 0, 0);
        send_command(CMD_GET_PULL, 0, 0, 0, 0, 0);
        send_command(CMD_SET_PULL, 0, 0, 0, 0, 0);
        send_command(CMD_GET_PULL, 0, 0, 0, 0, 0);
        send_command(CMD_SET_DRIVE, PIN_W'(PIN_COUNT - 1), 3, 0, 0, 0);
        send_command(CMD_GET_DRIVE, PIN_W'(PIN_COUNT - 1), 0, 0, 0, 0);
        send_command(CMD_SET_SLEW, PIN_W'(PIN_COUNT - 1), 1, 0, 0, 0);
        send_command(CMD_GET_SLEW, PIN_W'(PIN_COUNT - 1), 0, 0, 0, 0);
        send_command(CMD_SET_TYPE, 5, 2, 0, 0, 0);
        send_command(CMD_GET_TYPE, 5, 0, 0, 0, 0);
        send_command(CMD_WR_LEVEL, PIN_W'(PIN_COUNT - 1), 2, 0, 0, 0);
        send_command(CMD_RD_PAD, PIN_W'(PIN_COUNT - 1), 0, 0, 0, '1);
        send_command(CMD_MK_OUTPUT, 7, 1, 0, 0, 0);
        send_command(CMD_MK_INPUT, 7, 0, 0, 0, 0);
        send_command(CMD_FUNC_EN, 0, 0, FBIT_W'(FUNC_BITS - 1), 0, 0);
        send_command(CMD_FUNC_DIS, 0, 0, 0, 0, 0);
        send_command(CMD_IRQ_UNMASK, 0, 0, 0, LINE_W'(NUM_IRQ_LINES - 1), 0);
        send_command(CMD_IRQ_MASK, 0, 0, 0, 0, 0);
        send_command(CMD_IRQ_LINE, PIN_W'(IRQ_FIRST_PIN), 0, 0, 0, 0);
        send_command(CMD_IRQ_LINE, PIN_W'(IRQ_LAST_PIN), 0, 0, 0, 0);
        send_command(CMD_IRQ_LINE, PIN_W'(IRQ_FIRST_PIN - 1), 0, 0, 0, 0);
        // pin beyond the last one: write ignored, irq query errors
        send_command(CMD_IRQ_LINE, 31, 0, 0, 0, 0);
        send_command(CMD_SET_PULL, PIN_W'(PIN_COUNT), 1, 0, 0, 0);
        send_command(CMD_UNUSED_TOP, 31, 3, FBIT_W'(FUNC_BITS - 1),
                     LINE_W'(NUM_IRQ_LINES - 1), '1);

        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == RANDOM_ITEMS - QUIET_ITEMS)
                quiet = 1'b1;
            random_command();
        end
        cmd_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

[gpio_pin_config_controller.f]
design/gpcc_pkg.sv
design/gpcc_ctrl.sv
design/gpcc_datapath.sv
design/gpio_pin_config_controller.sv
tb/gpcc_checker.sv
tb/tb.sv
